### rtl/qmn_pkg.sv
// Shared widths and types for the quaternion multiply and normalize core.
`default_nettype none
package qmn_pkg;
    localparam int CB       = 16;
    localparam int FB       = 14;
    localparam int EP_W     = 18;
    localparam int P_W      = 20;
    localparam int M_W      = 30;
    localparam int NORM_MSB = 29;
    localparam int SH_W     = 5;
    localparam int SQ_W     = 60;
    localparam int S_W      = 62;
    localparam int R_W      = 31;
    localparam int Q_W      = 15;
    localparam int N_W      = 45;
    localparam int REM_W    = 32;
    localparam int SQ_ST    = 16;
    localparam int DV_ST    = 5;
    localparam int DV_STEP  = 3;

    typedef struct packed {
        logic                      zero;
        logic [3:0]                neg;
        logic [3:0][M_W-1:0]       mag;
    } t_side;
endpackage
`default_nettype wire

### rtl/quaternion_multiply_normalize_core.sv
// Top level: Hamilton product of two quaternions scaled to unit length.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_left_w..z, i_right_w..z (Q2.14)
//  output  | out       | o_valid / i_stall  | o_prod_w..z (Q2.14), o_zero_norm
//
// One transfer per cycle on each side while the output is not stalled.
// Stages: multiply, sum, max, normalize, square, add, 16 root stages,
// divide setup, 5 divide stages (3 quotient bits each), output register.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset is synchronous and clears only the valid bits.
`default_nettype none
module quaternion_multiply_normalize_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [qmn_pkg::CB-1:0] i_left_w,
    input  logic signed [qmn_pkg::CB-1:0] i_left_x,
    input  logic signed [qmn_pkg::CB-1:0] i_left_y,
    input  logic signed [qmn_pkg::CB-1:0] i_left_z,
    input  logic signed [qmn_pkg::CB-1:0] i_right_w,
    input  logic signed [qmn_pkg::CB-1:0] i_right_x,
    input  logic signed [qmn_pkg::CB-1:0] i_right_y,
    input  logic signed [qmn_pkg::CB-1:0] i_right_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [qmn_pkg::CB-1:0] o_prod_w,
    output logic signed [qmn_pkg::CB-1:0] o_prod_x,
    output logic signed [qmn_pkg::CB-1:0] o_prod_y,
    output logic signed [qmn_pkg::CB-1:0] o_prod_z,
    output logic                          o_zero_norm
);
    import qmn_pkg::*;

    function automatic logic signed [EP_W-1:0] rprod(input logic signed [CB-1:0] a,
                                                      input logic signed [CB-1:0] b);
        logic signed [2*CB:0] t;
        t = (2*CB+1)'(a * b) + (2*CB+1)'(1 << (FB - 1));
        return t[FB+EP_W-1:FB];
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // multiply
    logic signed [EP_W-1:0] r1_e [0:15];
    logic                   r1_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en) r1_vld <= i_valid;
        if (en) begin
            r1_e[0]  <= rprod(i_left_w, i_right_w);
            r1_e[1]  <= rprod(i_left_x, i_right_x);
            r1_e[2]  <= rprod(i_left_y, i_right_y);
            r1_e[3]  <= rprod(i_left_z, i_right_z);
            r1_e[4]  <= rprod(i_left_w, i_right_x);
            r1_e[5]  <= rprod(i_left_x, i_right_w);
            r1_e[6]  <= rprod(i_left_y, i_right_z);
            r1_e[7]  <= rprod(i_left_z, i_right_y);
            r1_e[8]  <= rprod(i_left_w, i_right_y);
            r1_e[9]  <= rprod(i_left_x, i_right_z);
            r1_e[10] <= rprod(i_left_y, i_right_w);
            r1_e[11] <= rprod(i_left_z, i_right_x);
            r1_e[12] <= rprod(i_left_w, i_right_z);
            r1_e[13] <= rprod(i_left_x, i_right_y);
            r1_e[14] <= rprod(i_left_y, i_right_x);
            r1_e[15] <= rprod(i_left_z, i_right_w);
        end
    end

    // sum
    logic signed [P_W-1:0] x1_e [0:15];
    for (genvar g = 0; g < 16; g++) begin : g_ext
        assign x1_e[g] = P_W'(r1_e[g]);
    end
    logic signed [P_W-1:0] r2_p [0:3];
    logic                  r2_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (en) r2_vld <= r1_vld;
        if (en) begin
            r2_p[0] <= x1_e[0] - x1_e[1] - x1_e[2] - x1_e[3];
            r2_p[1] <= x1_e[4] + x1_e[5] + x1_e[6] - x1_e[7];
            r2_p[2] <= x1_e[8] - x1_e[9] + x1_e[10] + x1_e[11];
            r2_p[3] <= x1_e[12] + x1_e[13] - x1_e[14] + x1_e[15];
        end
    end

    // magnitude and max
    logic [P_W-1:0] n3_mag [0:3];
    logic [P_W-1:0] n3_m;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n3_mag[i] = r2_p[i][P_W-1] ? P_W'(-r2_p[i]) : P_W'(r2_p[i]);
        end
        n3_m = n3_mag[0];
        for (int i = 1; i < 4; i++) begin
            if (n3_mag[i] > n3_m) n3_m = n3_mag[i];
        end
    end
    logic [P_W-1:0] r3_mag [0:3];
    logic [P_W-1:0] r3_m;
    logic [3:0]     r3_neg;
    logic           r3_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (en) r3_vld <= r2_vld;
        if (en) begin
            r3_mag <= n3_mag;
            r3_m   <= n3_m;
            for (int i = 0; i < 4; i++) r3_neg[i] <= r2_p[i][P_W-1];
        end
    end

    // normalize to [2^29, 2^30)
    logic [SH_W-1:0] n4_sh;
    always_comb begin
        logic [SH_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < P_W; b++) begin
            if (r3_m[b]) idx = SH_W'(b);
        end
        n4_sh = SH_W'(NORM_MSB) - idx;
    end
    t_side r4_side;
    logic  r4_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (en) r4_vld <= r3_vld;
        if (en) begin
            r4_side.zero <= (r3_m == '0);
            r4_side.neg  <= r3_neg;
            for (int i = 0; i < 4; i++) r4_side.mag[i] <= M_W'(r3_mag[i]) << n4_sh;
        end
    end

    // squares
    logic [SQ_W-1:0] r5_sq [0:3];
    t_side           r5_side;
    logic            r5_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (en) r5_vld <= r4_vld;
        if (en) begin
            r5_side <= r4_side;
            for (int i = 0; i < 4; i++) r5_sq[i] <= r4_side.mag[i] * r4_side.mag[i];
        end
    end

    // sum of squares
    logic [S_W-1:0] r6_s;
    t_side          r6_side;
    logic           r6_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else if (en) r6_vld <= r5_vld;
        if (en) begin
            r6_side <= r5_side;
            r6_s    <= S_W'(r5_sq[0]) + S_W'(r5_sq[1]) + S_W'(r5_sq[2]) + S_W'(r5_sq[3]);
        end
    end

    logic           q_vld;
    logic [R_W-1:0] q_root;
    t_side          q_side;
    qmn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r6_vld),
        .i_s     (r6_s),
        .i_side  (r6_side),
        .o_vld   (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    // divide setup: numerator with rounding term
    logic [REM_W-1:0] r7_rem [0:3];
    logic [Q_W-1:0]   r7_nl  [0:3];
    logic [R_W-1:0]   r7_r;
    logic [3:0]       r7_neg;
    logic             r7_zero;
    logic             r7_vld;
    always_ff @(posedge i_clk) begin
        logic [N_W-1:0] num;
        if (!i_rst_n) r7_vld <= 1'b0;
        else if (en) r7_vld <= q_vld;
        if (en) begin
            r7_r    <= q_root;
            r7_neg  <= q_side.neg;
            r7_zero <= q_side.zero;
            for (int i = 0; i < 4; i++) begin
                num = N_W'({q_side.mag[i], FB'(0)}) + N_W'(q_root >> 1);
                r7_rem[i] <= REM_W'(num[N_W-1:Q_W]);
                r7_nl[i]  <= num[Q_W-1:0];
            end
        end
    end

    // restoring division stages
    logic [REM_W-1:0] rd_rem [0:DV_ST-1][0:3];
    logic [Q_W-1:0]   rd_nl  [0:DV_ST-1][0:3];
    logic [Q_W-1:0]   rd_q   [0:DV_ST-1][0:3];
    logic [R_W-1:0]   rd_r   [0:DV_ST-1];
    logic [3:0]       rd_neg [0:DV_ST-1];
    logic             rd_zero[0:DV_ST-1];
    logic             rd_vld [0:DV_ST-1];

    for (genvar k = 0; k < DV_ST; k++) begin : g_div
        logic [REM_W-1:0] a_rem [0:3];
        logic [Q_W-1:0]   a_nl  [0:3];
        logic [Q_W-1:0]   a_q   [0:3];
        logic [R_W-1:0]   a_r;
        logic [3:0]       a_neg;
        logic             a_zero, a_vld;
        logic [REM_W-1:0] n_rem [0:3];
        logic [Q_W-1:0]   n_nl  [0:3];
        logic [Q_W-1:0]   n_q   [0:3];

        if (k == 0) begin : g_first
            assign a_rem  = r7_rem;
            assign a_nl   = r7_nl;
            assign a_q    = '{default: '0};
            assign a_r    = r7_r;
            assign a_neg  = r7_neg;
            assign a_zero = r7_zero;
            assign a_vld  = r7_vld;
        end else begin : g_next
            assign a_rem  = rd_rem[k-1];
            assign a_nl   = rd_nl[k-1];
            assign a_q    = rd_q[k-1];
            assign a_r    = rd_r[k-1];
            assign a_neg  = rd_neg[k-1];
            assign a_zero = rd_zero[k-1];
            assign a_vld  = rd_vld[k-1];
        end

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                n_rem[i] = a_rem[i];
                n_nl[i]  = a_nl[i];
                n_q[i]   = a_q[i];
                for (int j = 0; j < DV_STEP; j++) begin
                    n_rem[i] = {n_rem[i][REM_W-2:0], n_nl[i][Q_W-1]};
                    n_nl[i]  = n_nl[i] << 1;
                    if (n_rem[i] >= REM_W'(a_r)) begin
                        n_rem[i] = n_rem[i] - REM_W'(a_r);
                        n_q[i]   = {n_q[i][Q_W-2:0], 1'b1};
                    end else begin
                        n_q[i]   = {n_q[i][Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rd_vld[k] <= 1'b0;
            else if (en) rd_vld[k] <= a_vld;
            if (en) begin
                rd_rem[k]  <= n_rem;
                rd_nl[k]   <= n_nl;
                rd_q[k]    <= n_q;
                rd_r[k]    <= a_r;
                rd_neg[k]  <= a_neg;
                rd_zero[k] <= a_zero;
            end
        end
    end

    // sign, saturate, output register
    logic signed [CB-1:0] n_o [0:3];
    always_comb begin
        logic [CB:0] qe;
        for (int i = 0; i < 4; i++) begin
            qe = (CB+1)'(rd_q[DV_ST-1][i]);
            if (rd_zero[DV_ST-1]) begin
                n_o[i] = '0;
            end else if (rd_neg[DV_ST-1][i]) begin
                if (qe > (CB+1)'(1 << (CB - 1))) n_o[i] = CB'(1 << (CB - 1));
                else n_o[i] = CB'(-qe);
            end else begin
                if (qe > (CB+1)'((1 << (CB - 1)) - 1)) n_o[i] = CB'((1 << (CB - 1)) - 1);
                else n_o[i] = CB'(qe);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= rd_vld[DV_ST-1];
        if (en) begin
            o_prod_w    <= n_o[0];
            o_prod_x    <= n_o[1];
            o_prod_y    <= n_o[2];
            o_prod_z    <= n_o[3];
            o_zero_norm <= rd_zero[DV_ST-1];
        end
    end
endmodule
`default_nettype wire

### rtl/qmn_isqrt.sv
// Pipelined integer square root, two result bits per stage (one in the last stage).
`default_nettype none
module qmn_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [qmn_pkg::S_W-1:0]   i_s,
    input  qmn_pkg::t_side            i_side,
    output logic                      o_vld,
    output logic [qmn_pkg::R_W-1:0]   o_root,
    output qmn_pkg::t_side            o_side
);
    import qmn_pkg::*;

    logic [S_W-1:0] r_n   [0:SQ_ST-1];
    logic [S_W-1:0] r_res [0:SQ_ST-1];
    t_side          r_side[0:SQ_ST-1];
    logic           r_vld [0:SQ_ST-1];

    for (genvar k = 0; k < SQ_ST; k++) begin : g_st
        logic [S_W-1:0] a_n, a_res, n_n, n_res;
        t_side          a_side;
        logic           a_vld;

        if (k == 0) begin : g_first
            assign a_n    = i_s;
            assign a_res  = '0;
            assign a_side = i_side;
            assign a_vld  = i_vld;
        end else begin : g_next
            assign a_n    = r_n[k-1];
            assign a_res  = r_res[k-1];
            assign a_side = r_side[k-1];
            assign a_vld  = r_vld[k-1];
        end

        always_comb begin
            logic [S_W-1:0] b;
            b     = '0;
            n_n   = a_n;
            n_res = a_res;
            for (int j = 0; j < 2; j++) begin
                if (R_W - 1 - 2*k - j >= 0) begin
                    b = S_W'(1) << (2 * (R_W - 1 - 2*k - j));
                    if (n_n >= n_res + b) begin
                        n_n   = n_n - (n_res + b);
                        n_res = (n_res >> 1) + b;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
            if (i_en) begin
                r_n[k]    <= n_n;
                r_res[k]  <= n_res;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_vld  = r_vld[SQ_ST-1];
    assign o_root = r_res[SQ_ST-1][R_W-1:0];
    assign o_side = r_side[SQ_ST-1];
endmodule
`default_nettype wire
